[hdl/wfps_pkg.sv]
// shared types, constants and a helper function for the wall-follow steering block
package wfps_pkg;

  // fixed field widths
  localparam int GAIN_W   = 16;
  localparam int TGT_W    = 10;
  localparam int SPEED_W  = 8;
  localparam int STEER_W  = 6;
  localparam int DUTY_W   = 8;
  localparam int MIX_W    = 10;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  // steering shaping limits, in whole units
  localparam int STEER_LIMIT = 30;
  localparam int DEADBAND    = 5;

  // register reset values
  localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST    = 16'sd256;
  localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST   = 16'sd0;
  localparam logic        [TGT_W-1:0]  LEFT_TARGET_RST  = 10'd512;
  localparam logic        [TGT_W-1:0]  RIGHT_TARGET_RST = 10'd512;
  localparam logic        [SPEED_W-1:0] CRUISE_RST      = 8'd0;

  // register word index (byte address / 4)
  typedef enum logic [2:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_DERIV_GAIN   = 3'd1,
    REG_LEFT_TARGET  = 3'd2,
    REG_RIGHT_TARGET = 3'd3,
    REG_CRUISE_SPEED = 3'd4
  } reg_idx_t;

  // result payload of one transaction
  typedef struct packed {
    logic signed [STEER_W-1:0] steer;
    logic                      left_reverse;
    logic [DUTY_W-1:0]         left_duty;
    logic                      right_forward;
    logic [DUTY_W-1:0]         right_duty;
  } drive_t;

  // magnitude of a mixed speed, saturated to the pwm range
  function automatic logic [DUTY_W-1:0] duty_of(input logic signed [MIX_W-1:0] spd);
    logic [MIX_W-1:0] mag;
    mag = spd[MIX_W-1] ? MIX_W'(-spd) : MIX_W'(spd);
    duty_of = (mag > MIX_W'({DUTY_W{1'b1}})) ? {DUTY_W{1'b1}} : mag[DUTY_W-1:0];
  endfunction

endpackage

[hdl/wfps_steer_shape.sv]
// clamp, deadband, wall-side sign and truncation of the fixed-point pd term
module wfps_steer_shape #(
  parameter int TERM_W    = 29,
  parameter int FRAC_BITS = 8
) (
  input  logic signed [TERM_W-1:0]            term,
  input  logic                                on_left_wall,
  output logic signed [wfps_pkg::STEER_W-1:0] steer
);

  localparam logic signed [TERM_W-1:0] LIM_POS =
    TERM_W'(wfps_pkg::STEER_LIMIT * (1 << FRAC_BITS));
  localparam logic signed [TERM_W-1:0] LIM_NEG = -LIM_POS;
  localparam logic signed [TERM_W-1:0] DB_POS  =
    TERM_W'(wfps_pkg::DEADBAND * (1 << FRAC_BITS));
  localparam logic signed [TERM_W-1:0] DB_NEG  = -DB_POS;

  logic signed [TERM_W-1:0] clamped;
  logic signed [TERM_W-1:0] gated;
  logic signed [TERM_W-1:0] sided;
  logic        [TERM_W-1:0] mag;
  logic        [TERM_W-1:0] whole;
  logic [wfps_pkg::STEER_W-2:0] mag_s;

  always_comb begin
    if (term > LIM_POS) begin
      clamped = LIM_POS;
    end else if (term < LIM_NEG) begin
      clamped = LIM_NEG;
    end else begin
      clamped = term;
    end

    // open interval, exact edges are kept
    if (clamped > DB_NEG && clamped < DB_POS) begin
      gated = '0;
    end else begin
      gated = clamped;
    end

    sided = on_left_wall ? gated : -gated;

    // truncate toward zero: shift the magnitude, then restore the sign
    mag   = sided[TERM_W-1] ? TERM_W'(-sided) : TERM_W'(sided);
    whole = mag >> FRAC_BITS;
    mag_s = whole[wfps_pkg::STEER_W-2:0];
    steer = sided[TERM_W-1] ? -$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
  end

endmodule

[hdl/wall_follow_pd_steering.sv]
// top level: wall-follow pd steering with clamp, deadband and differential drive mix
// One transaction per clock cycle is taken at the input while in_stall is low.
// The sample lands in an input register, then a single pass of arithmetic
// (two gain multipliers, their sum, the clamp and deadband compares and the
// drive mix) feeds the result register. The error of every accepted sample is
// kept as the previous error for the next one, whichever wall it belongs to.
// in_stall only rises when both registers are full and the result side is
// stalling, so a new sample is taken while a finished result still waits.
// Configuration goes through the apb-style port, one 32-bit word per register
// at byte addresses 0, 4, 8, 12 and 16, decoded from paddr[4:2]; writes to
// word slots 5 to 7 are ignored and registers are meant to change only while idle.
module wall_follow_pd_steering #(
  parameter int SENSOR_BITS    = 10,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // sample channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [SENSOR_BITS-1:0]              in_side_sample,
  input  logic                                in_follow_left,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [wfps_pkg::STEER_W-1:0] out_steer,
  output logic                                out_left_reverse,
  output logic [wfps_pkg::DUTY_W-1:0]         out_left_duty,
  output logic                                out_right_forward,
  output logic [wfps_pkg::DUTY_W-1:0]         out_right_duty,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wfps_pkg::ADDR_W-1:0]         paddr,
  input  logic [wfps_pkg::DATA_W-1:0]         pwdata,
  output logic [wfps_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  // error spans the wider of sample and target, plus a sign bit
  localparam int ERR_W  = ((SENSOR_BITS > wfps_pkg::TGT_W) ? SENSOR_BITS
                                                           : wfps_pkg::TGT_W) + 1;
  localparam int DIFF_W = ERR_W + 1;
  localparam int PP_W   = wfps_pkg::GAIN_W + ERR_W;
  localparam int PD_W   = wfps_pkg::GAIN_W + DIFF_W;
  localparam int TERM_W = PD_W + 1;

  // configuration registers
  logic signed [wfps_pkg::GAIN_W-1:0]  prop_gain_r;
  logic signed [wfps_pkg::GAIN_W-1:0]  deriv_gain_r;
  logic        [wfps_pkg::TGT_W-1:0]   left_target_r;
  logic        [wfps_pkg::TGT_W-1:0]   right_target_r;
  logic        [wfps_pkg::SPEED_W-1:0] cruise_r;

  logic                cfg_wr;
  wfps_pkg::reg_idx_t  cfg_idx;

  // pipeline registers
  logic                     s1_vld_r;
  logic [SENSOR_BITS-1:0]   s1_sample_r;
  logic                     s1_left_r;
  logic signed [ERR_W-1:0]  prev_error_r;
  logic signed [ERR_W-1:0]  prev_error_nxt;
  logic                     out_vld_r;
  wfps_pkg::drive_t         drive_r;
  wfps_pkg::drive_t         drive_nxt;

  logic                     take_in;
  logic                     move;

  // datapath
  logic signed [ERR_W-1:0]  sample_s;
  logic signed [ERR_W-1:0]  target_s;
  logic signed [ERR_W-1:0]  err;
  logic signed [DIFF_W-1:0] err_diff;
  logic signed [PP_W-1:0]   prod_p;
  logic signed [PD_W-1:0]   prod_d;
  logic signed [TERM_W-1:0] term;
  logic signed [wfps_pkg::STEER_W-1:0] steer;
  logic signed [wfps_pkg::MIX_W-1:0]   left_spd;
  logic signed [wfps_pkg::MIX_W-1:0]   right_spd;
  logic signed [wfps_pkg::MIX_W-1:0]   cruise_s;
  logic signed [wfps_pkg::MIX_W-1:0]   steer_s;

  // ---------------------------------------------------------------------
  // configuration port: zero-wait writes, combinational read-back
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = wfps_pkg::reg_idx_t'(paddr[wfps_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r    <= wfps_pkg::PROP_GAIN_RST;
      deriv_gain_r   <= wfps_pkg::DERIV_GAIN_RST;
      left_target_r  <= wfps_pkg::LEFT_TARGET_RST;
      right_target_r <= wfps_pkg::RIGHT_TARGET_RST;
      cruise_r       <= wfps_pkg::CRUISE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        wfps_pkg::REG_PROP_GAIN: begin
          prop_gain_r <= $signed(pwdata[wfps_pkg::GAIN_W-1:0]);
        end
        wfps_pkg::REG_DERIV_GAIN: begin
          deriv_gain_r <= $signed(pwdata[wfps_pkg::GAIN_W-1:0]);
        end
        wfps_pkg::REG_LEFT_TARGET: begin
          left_target_r <= pwdata[wfps_pkg::TGT_W-1:0];
        end
        wfps_pkg::REG_RIGHT_TARGET: begin
          right_target_r <= pwdata[wfps_pkg::TGT_W-1:0];
        end
        wfps_pkg::REG_CRUISE_SPEED: begin
          cruise_r <= pwdata[wfps_pkg::SPEED_W-1:0];
        end
        default: begin
          // unmapped word, write dropped
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      wfps_pkg::REG_PROP_GAIN: begin
        prdata = {{(wfps_pkg::DATA_W-wfps_pkg::GAIN_W){1'b0}}, prop_gain_r};
      end
      wfps_pkg::REG_DERIV_GAIN: begin
        prdata = {{(wfps_pkg::DATA_W-wfps_pkg::GAIN_W){1'b0}}, deriv_gain_r};
      end
      wfps_pkg::REG_LEFT_TARGET: begin
        prdata = {{(wfps_pkg::DATA_W-wfps_pkg::TGT_W){1'b0}}, left_target_r};
      end
      wfps_pkg::REG_RIGHT_TARGET: begin
        prdata = {{(wfps_pkg::DATA_W-wfps_pkg::TGT_W){1'b0}}, right_target_r};
      end
      wfps_pkg::REG_CRUISE_SPEED: begin
        prdata = {{(wfps_pkg::DATA_W-wfps_pkg::SPEED_W){1'b0}}, cruise_r};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // flow control: input register feeds result register
  // ---------------------------------------------------------------------
  // result register can load when empty or when its transaction leaves now
  assign move     = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !move;
  assign take_in  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (take_in) begin
      s1_vld_r <= 1'b1;
    end else if (move) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_sample_r <= in_side_sample;
      s1_left_r   <= in_follow_left;
    end
  end

  // ---------------------------------------------------------------------
  // pd term
  // ---------------------------------------------------------------------
  // error against the chosen wall's setpoint
  assign sample_s = $signed(ERR_W'(s1_sample_r));
  assign target_s = $signed(ERR_W'(s1_left_r ? left_target_r : right_target_r));
  assign err      = sample_s - target_s;

  // derivative uses the last error, whichever wall produced it
  assign err_diff = {err[ERR_W-1], err} - {prev_error_r[ERR_W-1], prev_error_r};

  assign prod_p = prop_gain_r * err;
  assign prod_d = deriv_gain_r * err_diff;
  assign term   = TERM_W'(prod_p) + TERM_W'(prod_d);

  assign prev_error_nxt = move ? err : prev_error_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_error_r <= '0;
    end else begin
      prev_error_r <= prev_error_nxt;
    end
  end

  // clamp, deadband, side sign and drop of the fraction bits
  wfps_steer_shape #(
    .TERM_W    (TERM_W),
    .FRAC_BITS (GAIN_FRAC_BITS)
  ) u_shape (
    .term         (term),
    .on_left_wall (s1_left_r),
    .steer        (steer)
  );

  // ---------------------------------------------------------------------
  // differential drive mix
  // ---------------------------------------------------------------------
  assign cruise_s  = $signed(wfps_pkg::MIX_W'(cruise_r));
  assign steer_s   = wfps_pkg::MIX_W'(steer);
  assign left_spd  = cruise_s - steer_s;
  assign right_spd = cruise_s + steer_s;

  always_comb begin
    drive_nxt.steer         = steer;
    // zero speed counts as reverse on the left and not forward on the right
    drive_nxt.left_reverse  = (left_spd <= 0);
    drive_nxt.left_duty     = wfps_pkg::duty_of(left_spd);
    drive_nxt.right_forward = (right_spd > 0);
    drive_nxt.right_duty    = wfps_pkg::duty_of(right_spd);
  end

  // ---------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (move) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      drive_r <= drive_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_steer         = drive_r.steer;
  assign out_left_reverse  = drive_r.left_reverse;
  assign out_left_duty     = drive_r.left_duty;
  assign out_right_forward = drive_r.right_forward;
  assign out_right_duty    = drive_r.right_duty;

`ifndef ASSERT_OFF
  // a transaction leaving the input register always shows up as a result
  a_move_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> out_vld_r)
    else $error("result register not loaded after transfer");

  // previous error only changes when a transaction is processed
  a_prev_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !move) |=> $stable(prev_error_r))
    else $error("previous error changed without a transaction");

  // steer is zero or within the band between deadband and clamp
  a_steer_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (drive_r.steer == 0) ||
                  (drive_r.steer >= 6'sd5 && drive_r.steer <= 6'sd30) ||
                  (drive_r.steer <= -6'sd5 && drive_r.steer >= -6'sd30))
    else $error("steer outside shaped range");

  // a stopped wheel reports reverse on the left and not forward on the right
  a_zero_speed_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (drive_r.left_duty != 0 || drive_r.left_reverse) &&
                  (drive_r.right_duty != 0 || !drive_r.right_forward))
    else $error("direction bit wrong at zero speed");
`endif

endmodule

[bench/wall_follow_pd_steering_test.sv]
// self-checking testbench for the wall-follow pd steering block
module wall_follow_pd_steering_test;

  // q8.8 gains: one whole unit of the pd term
  localparam int        FRAC_BITS = 8;
  localparam longint    UNIT      = longint'(1) << FRAC_BITS;
  // register slots past the last real one, writes there must be ignored
  localparam int        SPARE_REG_FIRST = 5;
  localparam int        SPARE_REG_LAST  = 7;
  localparam int        RAND_PHASES     = 16;
  localparam int        PHASE_ITEMS     = 102;

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_stall;
  logic [9:0]                          in_side_sample;
  logic                                in_follow_left;
  logic                                out_valid;
  logic                                out_stall;
  logic signed [wfps_pkg::STEER_W-1:0] out_steer;
  logic                                out_left_reverse;
  logic [wfps_pkg::DUTY_W-1:0]         out_left_duty;
  logic                                out_right_forward;
  logic [wfps_pkg::DUTY_W-1:0]         out_right_duty;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [wfps_pkg::ADDR_W-1:0]         paddr;
  logic [wfps_pkg::DATA_W-1:0]         pwdata;
  logic [wfps_pkg::DATA_W-1:0]         prdata;
  logic                                pready;

  // our copy of the control settings and the shared error history
  logic signed [wfps_pkg::GAIN_W-1:0] kp_q88      = wfps_pkg::PROP_GAIN_RST;
  logic signed [wfps_pkg::GAIN_W-1:0] kd_q88      = wfps_pkg::DERIV_GAIN_RST;
  logic [wfps_pkg::TGT_W-1:0]         left_set    = wfps_pkg::LEFT_TARGET_RST;
  logic [wfps_pkg::TGT_W-1:0]         right_set   = wfps_pkg::RIGHT_TARGET_RST;
  logic [wfps_pkg::SPEED_W-1:0]       cruise_copy = wfps_pkg::CRUISE_RST;
  logic signed [11:0]                 last_err    = '0;

  wfps_pkg::drive_t           pending_drive[$];
  int                         mismatch_count = 0;
  // when set the sample side sends back to back
  bit                         steady = 1'b0;

  wall_follow_pd_steering dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_side_sample    (in_side_sample),
    .in_follow_left    (in_follow_left),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_steer         (out_steer),
    .out_left_reverse  (out_left_reverse),
    .out_left_duty     (out_left_duty),
    .out_right_forward (out_right_forward),
    .out_right_duty    (out_right_duty),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  initial begin
    #12_000_000;
    $display("wall_follow_pd_steering: mismatch");
    $finish;
  end

  // pwm magnitude of a mixed wheel speed, clipped to 8 bits
  function automatic logic [wfps_pkg::DUTY_W-1:0] pwm_mag(input longint spd);
    longint m;
    m = (spd < 0) ? -spd : spd;
    return (m > 255) ? 8'd255 : wfps_pkg::DUTY_W'(m);
  endfunction

  // expected drive for one sample; also advances the error history
  function automatic wfps_pkg::drive_t steer_for(input logic [9:0] s, input logic lft);
    longint e;
    longint term;
    longint st;
    longint lsp;
    longint rsp;
    wfps_pkg::drive_t d;
    e    = longint'(s) - longint'(lft ? left_set : right_set);
    term = longint'(kp_q88) * e + longint'(kd_q88) * (e - longint'(last_err));
    last_err = 12'(e);
    // clamp first, then the deadband, so exactly +/-5 survives
    if (term > wfps_pkg::STEER_LIMIT * UNIT) term = wfps_pkg::STEER_LIMIT * UNIT;
    if (term < -wfps_pkg::STEER_LIMIT * UNIT) term = -wfps_pkg::STEER_LIMIT * UNIT;
    if (term > -wfps_pkg::DEADBAND * UNIT && term < wfps_pkg::DEADBAND * UNIT) term = 0;
    if (!lft) term = -term;
    // signed division drops the fraction toward zero
    st  = term / UNIT;
    lsp = longint'(cruise_copy) - st;
    rsp = longint'(cruise_copy) + st;
    d.steer         = st[wfps_pkg::STEER_W-1:0];
    d.left_reverse  = (lsp <= 0);
    d.left_duty     = pwm_mag(lsp);
    d.right_forward = (rsp > 0);
    d.right_duty    = pwm_mag(rsp);
    return d;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // reading within +/-40 of the chosen wall's setpoint
  function automatic logic [9:0] near_target(input logic lft);
    int c;
    c = int'(lft ? left_set : right_set) + int'($urandom_range(0, 80)) - 40;
    if (c < 0) c = 0;
    if (c > 1023) c = 1023;
    return 10'(c);
  endfunction

  // gain word with junk in the upper half, the block must ignore it
  function automatic logic [31:0] gain_word();
    logic [15:0] g;
    case ($urandom_range(0, 7))
      0: g = 16'h7FFF;
      1: g = 16'h8000;
      2: g = 16'h0000;
      3, 4, 5: g = 16'(int'($urandom_range(0, 1024)) - 512);
      default: g = 16'($urandom);
    endcase
    return {16'($urandom), g};
  endfunction

  function automatic logic [31:0] target_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 3))
      0: w[9:0] = 10'd0;
      1: w[9:0] = 10'd1023;
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] speed_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 3))
      0: w[7:0] = 8'd0;
      1: w[7:0] = 8'd255;
      default: ;
    endcase
    return w;
  endfunction

  // result side: random stall bursts between calm stretches, some very long
  initial begin : result_backpressure
    int calm;
    int gap;
    out_stall <= 1'b0;
    forever begin
      calm = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 10);
      repeat (calm) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // compare every accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    wfps_pkg::drive_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_drive.size() == 0) begin
        $display("%0t: result transaction with nothing expected (steer %0d)", $time,
                 out_steer);
        mismatch_count++;
      end else begin
        want = pending_drive.pop_front();
        if (out_steer !== want.steer) begin
          $display("%0t: steer expected %0d got %0d", $time, want.steer, out_steer);
          mismatch_count++;
        end
        if (out_left_reverse !== want.left_reverse) begin
          $display("%0t: left_reverse expected %0b got %0b", $time, want.left_reverse,
                   out_left_reverse);
          mismatch_count++;
        end
        if (out_left_duty !== want.left_duty) begin
          $display("%0t: left_duty expected %0d got %0d", $time, want.left_duty,
                   out_left_duty);
          mismatch_count++;
        end
        if (out_right_forward !== want.right_forward) begin
          $display("%0t: right_forward expected %0b got %0b", $time, want.right_forward,
                   out_right_forward);
          mismatch_count++;
        end
        if (out_right_duty !== want.right_duty) begin
          $display("%0t: right_duty expected %0d got %0d", $time, want.right_duty,
                   out_right_duty);
          mismatch_count++;
        end
      end
    end
  end

  // one sample transaction; valid stays up into the next call unless a gap follows
  task automatic send_sample(input logic [9:0] s, input logic lft);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_side_sample <= s;
    in_follow_left <= lft;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_drive.push_back(steer_for(s, lft));
  endtask

  // drop valid and let the pipeline empty before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // setup then access phase; the model copy follows the register map
  task automatic write_reg(input int idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= wfps_pkg::ADDR_W'(idx * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      wfps_pkg::REG_PROP_GAIN:    kp_q88      = value[15:0];
      wfps_pkg::REG_DERIV_GAIN:   kd_q88      = value[15:0];
      wfps_pkg::REG_LEFT_TARGET:  left_set    = value[9:0];
      wfps_pkg::REG_RIGHT_TARGET: right_set   = value[9:0];
      wfps_pkg::REG_CRUISE_SPEED: cruise_copy = value[7:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [31:0] kp, input logic [31:0] kd,
                           input logic [31:0] lt, input logic [31:0] rt,
                           input logic [31:0] cs);
    write_reg(wfps_pkg::REG_PROP_GAIN, kp);
    write_reg(wfps_pkg::REG_DERIV_GAIN, kd);
    write_reg(wfps_pkg::REG_LEFT_TARGET, lt);
    write_reg(wfps_pkg::REG_RIGHT_TARGET, rt);
    write_reg(wfps_pkg::REG_CRUISE_SPEED, cs);
  endtask

  // reset settings: unit gain, centered setpoints, zero cruise
  task automatic test_reset_values();
    send_sample(10'd512, 1'b1);   // zero error, zero speed on both wheels
    send_sample(10'd517, 1'b1);   // exactly +5 is kept
    send_sample(10'd516, 1'b1);   // +4 falls in the deadband
    send_sample(10'd507, 1'b0);   // -5 on the right wall flips to +5
    send_sample(10'd1023, 1'b1);  // clamps at the top
    send_sample(10'd0, 1'b0);     // clamps at the bottom
  endtask

  // extreme gains, setpoints and cruise, wheel speed saturation
  task automatic test_extremes();
    settle();
    write_all(32'h0000_7FFF, 32'h0000_8000, 32'd0, 32'd1023, 32'd255);
    send_sample(10'd1023, 1'b1);
    send_sample(10'd0, 1'b1);
    send_sample(10'd0, 1'b0);
    send_sample(10'd1023, 1'b0);
    settle();
    write_reg(wfps_pkg::REG_CRUISE_SPEED, 32'd0);
    send_sample(10'd1023, 1'b1);
  endtask

  // fractional gain, truncation toward zero on both signs, masked upper bits
  task automatic test_truncation();
    settle();
    write_all(32'hABCD_0180, 32'hFFFF_0000, 32'hFFFF_FE00, 32'h1234_0200, 32'h0000_FF64);
    send_sample(10'd517, 1'b1);   // 7.5 -> 7
    send_sample(10'd517, 1'b0);   // -7.5 -> -7
    send_sample(10'd507, 1'b1);   // -7.5 -> -7
    send_sample(10'd516, 1'b1);   // 6.0 stays 6
  endtask

  // derivative only: the error history carries over a change of wall
  task automatic test_side_switch();
    settle();
    write_all(32'd0, 32'd256, 32'd300, 32'd700, 32'd40);
    send_sample(10'd310, 1'b1);
    send_sample(10'd690, 1'b0);
    send_sample(10'd310, 1'b1);
    send_sample(10'd700, 1'b0);
  endtask

  // writes past the register map leave every setting alone
  task automatic test_unmapped_write();
    settle();
    for (int i = SPARE_REG_FIRST; i <= SPARE_REG_LAST; i++) write_reg(i, 32'hFFFF_FFFF);
    send_sample(10'd320, 1'b1);
    send_sample(10'd650, 1'b0);
  endtask

  // random settings per phase, runs of one wall with occasional switches
  task automatic test_random();
    logic side;
    logic [9:0] s;
    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      steady = (p % 4 == 3);
      if (p == 0)
        write_all(32'h0000_7FFF, 32'h0000_7FFF, 32'd1023, 32'd0, 32'd255);
      else if (p == 1)
        write_all(32'h0000_8000, 32'h0000_8000, 32'd0, 32'd1023, 32'd0);
      else
        write_all(gain_word(), gain_word(), target_word(), target_word(), speed_word());
      side = 1'($urandom);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 15) side = ~side;
        s = ($urandom_range(0, 99) < 60) ? near_target(side) : 10'($urandom);
        send_sample(s, side);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_side_sample <= '0;
    in_follow_left <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_extremes();
    test_truncation();
    test_side_switch();
    test_unmapped_write();
    test_random();
    // let the last transactions drain, then wait for strays
    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("wall_follow_pd_steering: match");
    end else begin
      $display("wall_follow_pd_steering: mismatch");
    end
    $finish;
  end

endmodule
